// ===== rtl/art_pkg.sv =====
package art_pkg;

  localparam int unsigned MAX_ROUTES_DEF = 16;
  localparam int unsigned KEY_BITS_DEF   = 48;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned METRIC_W  = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [TIME_W-1:0] TIMEOUT_RST  = 32'd30000;
  localparam logic [TIME_W-1:0] INTERVAL_RST = 32'd10000;

  typedef enum logic [MODE_W-1:0] {
    MODE_UPDATE,
    MODE_TICK,
    MODE_REMOVE,
    MODE_INIT
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED,
    ST_INSERTED,
    ST_EVICTED,
    ST_REMOVED,
    ST_NOT_FOUND,
    ST_TICK_DONE,
    ST_CLEARED
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT,
    CFG_INTERVAL
  } cfg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_EVICT,
    S_APPEND,
    S_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic evict_start;
    logic append;
    logic emit;
  } art_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic  scan_done;
    logic  found;
    logic  full;
    logic  evicting;
    mode_e mode;
  } art_stat_t;

  function automatic int unsigned cnt_width(input int unsigned n);
    return $clog2(n + 1);
  endfunction

  function automatic int unsigned idx_width(input int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== rtl/art_in_if.sv =====
interface art_in_if #(
  parameter int unsigned KEY_W = art_pkg::KEY_BITS_DEF
) ();
  import art_pkg::*;

  logic                valid;
  logic                ready;
  mode_e               mode;
  logic [KEY_W-1:0]    route_key;
  logic [METRIC_W-1:0] metric;
  logic [TIME_W-1:0]   now_ms;

  modport source (output valid, output mode, output route_key, output metric,
                  output now_ms, input ready);
  modport sink   (input valid, input mode, input route_key, input metric,
                  input now_ms, output ready);
endinterface

// ===== rtl/art_out_if.sv =====
interface art_out_if #(
  parameter int unsigned CNT_W = art_pkg::cnt_width(art_pkg::MAX_ROUTES_DEF)
) ();
  import art_pkg::*;

  logic             valid;
  logic             ready;
  status_e          status;
  logic [CNT_W-1:0] aged_count;
  logic             update_due;
  logic [CNT_W-1:0] route_count;

  modport source (output valid, output status, output aged_count, output update_due,
                  output route_count, input ready);
  modport sink   (input valid, input status, input aged_count, input update_due,
                  input route_count, output ready);
endinterface

// ===== rtl/art_ctrl.sv =====
module art_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  art_pkg::mode_e     in_mode_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  art_pkg::art_stat_t stat_i,
  output art_pkg::art_cmd_t  cmd_o
);
  import art_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = (in_mode_i == MODE_INIT) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.scan_done) begin
          if (stat_i.mode == MODE_UPDATE && !stat_i.found) begin
            // a miss on a full table drops the oldest route before the append
            state_d = (stat_i.full && !stat_i.evicting) ? S_EVICT : S_APPEND;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_EVICT:  state_d = S_SCAN;
      S_APPEND: state_d = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = accept;
    cmd_o.scan        = (state_q == S_SCAN);
    cmd_o.commit      = (state_q == S_SCAN) && stat_i.scan_done;
    cmd_o.evict_start = (state_q == S_EVICT);
    cmd_o.append      = (state_q == S_APPEND);
    cmd_o.emit        = (state_q == S_FINISH) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_SCAN || state_q == S_FINISH))
    else $error("accepted item did not start work");

  a_append_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_APPEND) |-> ($past(state_q) == S_SCAN && $past(stat_i.mode) == MODE_UPDATE))
    else $error("append without a preceding update scan");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result withdrawn before transfer");

endmodule

// ===== rtl/art_dp.sv =====
module art_dp #(
  parameter int unsigned MAX_ROUTES = art_pkg::MAX_ROUTES_DEF,
  parameter int unsigned KEY_BITS   = art_pkg::KEY_BITS_DEF,
  localparam int unsigned CNT_W     = art_pkg::cnt_width(MAX_ROUTES),
  localparam int unsigned IDX_W     = art_pkg::idx_width(MAX_ROUTES)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  art_pkg::art_cmd_t               cmd_i,
  output art_pkg::art_stat_t              stat_o,
  input  art_pkg::mode_e                  mode_i,
  input  logic [KEY_BITS-1:0]             route_key_i,
  input  logic [art_pkg::METRIC_W-1:0]    metric_i,
  input  logic [art_pkg::TIME_W-1:0]      now_ms_i,
  input  logic                            cfg_we_i,
  input  logic [art_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [art_pkg::CFG_W-1:0]       cfg_wdata_i,
  output art_pkg::status_e                status_o,
  output logic [CNT_W-1:0]                aged_count_o,
  output logic                            update_due_o,
  output logic [CNT_W-1:0]                route_count_o
);
  import art_pkg::*;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [METRIC_W-1:0] metric;
    logic [TIME_W-1:0]   last_seen;
  } entry_t;

  entry_t mem [MAX_ROUTES];
  entry_t rd_q;

  // item registers
  mode_e               mode_q;
  logic [KEY_BITS-1:0] key_q;
  logic [METRIC_W-1:0] metric_q;
  logic [TIME_W-1:0]   now_q;

  // control state
  logic [CNT_W-1:0]  count_q;
  logic [CNT_W-1:0]  rd_idx_q;
  logic [CNT_W-1:0]  wr_idx_q;
  logic [CNT_W-1:0]  aged_q;
  logic              pend_q;
  logic              found_q;
  logic              evict_q;
  logic [TIME_W-1:0] last_upd_q;
  logic [TIME_W-1:0] timeout_q;
  logic [TIME_W-1:0] interval_q;

  // result registers
  status_e           status_q;
  logic [CNT_W-1:0]  aged_out_q;
  logic              due_out_q;
  logic [CNT_W-1:0]  rcount_q;

  logic              issue;
  logic              proc;
  logic              match;
  logic              stale;
  logic              drop;
  logic              keep;
  logic              due;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  entry_t            new_entry;
  logic [TIME_W-1:0] age;
  logic [TIME_W-1:0] since_upd;
  status_e           status_d;

  // scan: read entry r, the cycle after decide and write it back compacted at w <= r
  assign issue     = cmd_i.scan && (rd_idx_q < count_q);
  assign proc      = cmd_i.scan && pend_q;
  assign match     = (rd_q.key == key_q);
  assign age       = now_q - rd_q.last_seen;
  assign stale     = age > timeout_q;
  assign since_upd = now_q - last_upd_q;
  assign due       = since_upd >= interval_q;
  assign new_entry = '{key: key_q, metric: metric_q, last_seen: now_q};

  always_comb begin
    drop = 1'b0;
    if (evict_q) begin
      drop = (rd_idx_q == CNT_W'(1));
    end else begin
      case (mode_q)
        MODE_TICK:   drop = stale;
        MODE_REMOVE: drop = match;
        default:     drop = 1'b0;
      endcase
    end
  end

  assign keep  = proc && !drop;
  assign wr_en = keep || cmd_i.append;

  always_comb begin
    wr_addr = wr_idx_q[IDX_W-1:0];
    wr_data = rd_q;
    if (cmd_i.append) begin
      wr_addr = count_q[IDX_W-1:0];
      wr_data = new_entry;
    end else if (mode_q == MODE_UPDATE && match && !evict_q) begin
      wr_data = new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_q <= mem[rd_idx_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      key_q    <= route_key_i;
      metric_q <= metric_i;
      now_q    <= now_ms_i;
    end
  end

  always_comb begin
    case (mode_q)
      MODE_UPDATE: status_d = found_q ? ST_UPDATED : (evict_q ? ST_EVICTED : ST_INSERTED);
      MODE_TICK:   status_d = ST_TICK_DONE;
      MODE_REMOVE: status_d = found_q ? ST_REMOVED : ST_NOT_FOUND;
      default:     status_d = ST_CLEARED;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q   <= status_d;
      aged_out_q <= (mode_q == MODE_TICK) ? aged_q : '0;
      due_out_q  <= (mode_q == MODE_TICK) && due;
      rcount_q   <= (mode_q == MODE_INIT) ? '0 : count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      aged_q     <= '0;
      pend_q     <= 1'b0;
      found_q    <= 1'b0;
      evict_q    <= 1'b0;
      last_upd_q <= '0;
      timeout_q  <= TIMEOUT_RST;
      interval_q <= INTERVAL_RST;
    end else begin
      if (cmd_i.load) begin
        rd_idx_q <= '0;
        wr_idx_q <= '0;
        aged_q   <= '0;
        pend_q   <= 1'b0;
        found_q  <= 1'b0;
        evict_q  <= 1'b0;
      end
      if (cmd_i.scan) begin
        pend_q <= issue;
        if (issue) begin
          rd_idx_q <= rd_idx_q + CNT_W'(1);
        end
        if (keep) begin
          wr_idx_q <= wr_idx_q + CNT_W'(1);
        end
        if (proc && match && !evict_q) begin
          found_q <= 1'b1;
        end
        if (proc && drop && !evict_q && mode_q == MODE_TICK) begin
          aged_q <= aged_q + CNT_W'(1);
        end
      end
      if (cmd_i.commit) begin
        count_q <= wr_idx_q;
      end
      if (cmd_i.evict_start) begin
        rd_idx_q <= '0;
        wr_idx_q <= '0;
        pend_q   <= 1'b0;
        evict_q  <= 1'b1;
      end
      if (cmd_i.append) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (cmd_i.emit) begin
        if (mode_q == MODE_INIT) begin
          count_q    <= '0;
          last_upd_q <= now_q;
        end else if (mode_q == MODE_TICK && due) begin
          last_upd_q <= now_q;
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TIMEOUT:  timeout_q  <= cfg_wdata_i;
          CFG_INTERVAL: interval_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  assign stat_o.scan_done = !pend_q && (rd_idx_q == count_q);
  assign stat_o.found     = found_q;
  assign stat_o.full      = (wr_idx_q == CNT_W'(MAX_ROUTES));
  assign stat_o.evicting  = evict_q;
  assign stat_o.mode      = mode_q;

  assign status_o      = status_q;
  assign aged_count_o  = aged_out_q;
  assign update_due_o  = due_out_q;
  assign route_count_o = rcount_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ROUTES))
    else $error("route count above table size");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_idx_q <= rd_idx_q)
    else $error("compaction write pointer overtook read pointer");

  a_aged_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (aged_q + wr_idx_q) <= rd_idx_q)
    else $error("aged count exceeds entries scanned");

endmodule

// ===== rtl/aging_route_table.sv =====
// From input transfer to result in the output register: clear goes straight to the result;
// update, remove and tick scan the stored routes; an insert adds an append step,
// and an insert into a full table adds a second scan that evicts the oldest route.
// Items are handled one at a time, one table entry per cycle through a sequential scan;
// the next item is taken as soon as the previous result is in the output register.
// Reset clears the route count and interval timer and loads the timeout and interval defaults.
module aging_route_table #(
  parameter int unsigned MAX_ROUTES = art_pkg::MAX_ROUTES_DEF,
  parameter int unsigned KEY_BITS   = art_pkg::KEY_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  art_in_if.sink                        in_i,
  art_out_if.source                     out_o,
  input  logic                          cfg_we_i,
  input  logic [art_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [art_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import art_pkg::*;

  art_cmd_t  cmd;
  art_stat_t stat;

  art_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_mode_i   (in_i.mode),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  art_dp #(
    .MAX_ROUTES (MAX_ROUTES),
    .KEY_BITS   (KEY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .mode_i        (in_i.mode),
    .route_key_i   (in_i.route_key),
    .metric_i      (in_i.metric),
    .now_ms_i      (in_i.now_ms),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (out_o.status),
    .aged_count_o  (out_o.aged_count),
    .update_due_o  (out_o.update_due),
    .route_count_o (out_o.route_count)
  );

endmodule

// ===== tb/aging_route_table_tb.sv =====
`timescale 1ns / 100ps

module aging_route_table_tb;
  import art_pkg::*;

  localparam int unsigned MAX_ROUTES  = MAX_ROUTES_DEF;
  localparam int unsigned KEY_W       = KEY_BITS_DEF;
  localparam int unsigned CNT_W       = cnt_width(MAX_ROUTES);
  localparam int unsigned KEY_POOL    = 24;
  localparam int unsigned SETTLE_CYC  = 2 * MAX_ROUTES + 8;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG    = 5000;
  localparam int unsigned PHASE_ITEMS = 265;

  typedef struct {
    mode_e                 mode;
    logic [KEY_W-1:0]      key;
    logic [METRIC_W-1:0]   metric;
    logic [TIME_W-1:0]     now;
  } route_op_t;

  typedef struct {
    status_e               status;
    logic [CNT_W-1:0]      aged;
    logic                  upd_due;
    logic [CNT_W-1:0]      count;
  } route_res_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;

  art_in_if  #(.KEY_W(KEY_W)) in_if ();
  art_out_if #(.CNT_W(CNT_W)) out_if ();

  aging_route_table #(
    .MAX_ROUTES(MAX_ROUTES),
    .KEY_BITS  (KEY_W)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  // shadow copy of the route table
  logic [KEY_W-1:0]    tbl_key    [MAX_ROUTES];
  logic [METRIC_W-1:0] tbl_metric [MAX_ROUTES];
  logic [TIME_W-1:0]   tbl_seen   [MAX_ROUTES];
  int unsigned         tbl_count;
  logic [TIME_W-1:0]   last_bcast;
  logic [TIME_W-1:0]   timeout_reg;
  logic [TIME_W-1:0]   interval_reg;

  route_op_t   op_pend_q[$];
  route_res_t  route_exp_q[$];
  route_op_t   acc_op;
  route_op_t   nxt_op;
  route_res_t  want;

  logic [KEY_W-1:0]  key_pool [KEY_POOL];
  logic [TIME_W-1:0] gen_now;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  logic        hold_arm;
  logic        hold_done;
  int unsigned hold_cnt;
  int unsigned idle_cycles;
  int unsigned errors;

  function automatic int table_find(logic [KEY_W-1:0] key);
    for (int i = 0; i < int'(tbl_count); i++)
      if (tbl_key[i] == key) return i;
    return -1;
  endfunction

  // close the gap left by the entry at pos, keeping insertion order
  function automatic void table_drop(int unsigned pos);
    for (int unsigned j = pos; j + 1 < tbl_count; j++) begin
      tbl_key[j]    = tbl_key[j + 1];
      tbl_metric[j] = tbl_metric[j + 1];
      tbl_seen[j]   = tbl_seen[j + 1];
    end
    if (tbl_count > 0) tbl_count--;
  endfunction

  function automatic route_res_t table_apply(route_op_t op);
    route_res_t        res;
    int                pos;
    logic [TIME_W-1:0] age;
    res.status  = ST_UPDATED;
    res.aged    = '0;
    res.upd_due = 1'b0;
    case (op.mode)
      MODE_UPDATE: begin
        pos = table_find(op.key);
        if (pos >= 0) begin
          tbl_metric[pos] = op.metric;
          tbl_seen[pos]   = op.now;
          res.status      = ST_UPDATED;
        end else begin
          res.status = ST_INSERTED;
          if (tbl_count >= MAX_ROUTES) begin
            table_drop(0);
            res.status = ST_EVICTED;
          end
          tbl_key[tbl_count]    = op.key;
          tbl_metric[tbl_count] = op.metric;
          tbl_seen[tbl_count]   = op.now;
          tbl_count++;
        end
      end
      MODE_TICK: begin
        for (int i = int'(tbl_count) - 1; i >= 0; i--) begin
          age = op.now - tbl_seen[i];
          if (age > timeout_reg) begin
            table_drop(unsigned'(i));
            res.aged = res.aged + 1'b1;
          end
        end
        age = op.now - last_bcast;
        if (age >= interval_reg) begin
          res.upd_due = 1'b1;
          last_bcast  = op.now;
        end
        res.status = ST_TICK_DONE;
      end
      MODE_REMOVE: begin
        pos = table_find(op.key);
        if (pos >= 0) begin
          table_drop(unsigned'(pos));
          res.status = ST_REMOVED;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      default: begin
        tbl_count  = 0;
        last_bcast = op.now;
        res.status = ST_CLEARED;
      end
    endcase
    res.count = CNT_W'(tbl_count);
    return res;
  endfunction

  function automatic void queue_op(mode_e mode, logic [KEY_W-1:0] key,
                                   logic [METRIC_W-1:0] metric, logic [TIME_W-1:0] now);
    route_op_t op;
    op.mode   = mode;
    op.key    = key;
    op.metric = metric;
    op.now    = now;
    op_pend_q.insert(op_pend_q.size(), op);
  endfunction

  function automatic void queue_random_op(int unsigned step_max);
    int unsigned      pick;
    mode_e            mode;
    logic [KEY_W-1:0] key;
    pick = $urandom_range(99);
    if (pick < 55)      mode = MODE_UPDATE;
    else if (pick < 80) mode = MODE_TICK;
    else if (pick < 96) mode = MODE_REMOVE;
    else                mode = MODE_INIT;
    // occasional jump anywhere on the clock, wrap included
    if ($urandom_range(99) < 3) gen_now = $urandom;
    else gen_now = gen_now + $urandom_range(step_max);
    if ($urandom_range(99) < 85) key = key_pool[$urandom_range(KEY_POOL - 1)];
    else key = {16'($urandom), $urandom};
    queue_op(mode, key, 16'($urandom), gen_now);
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    if (idx == CFG_TIMEOUT) timeout_reg = value;
    else interval_reg = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (op_pend_q.size() != 0 || route_exp_q.size() != 0 || in_if.valid);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned send_idle, int unsigned recv_stall,
                           int unsigned step_max, logic hold);
    @(negedge clk_i);
    send_idle_pct  = send_idle;
    recv_stall_pct = recv_stall;
    hold_arm       = hold;
    repeat (PHASE_ITEMS) queue_random_op(step_max);
    wait_drained();
  endtask

  // sender: holds an item until it is transferred
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.mode      <= MODE_UPDATE;
      in_if.route_key <= '0;
      in_if.metric    <= '0;
      in_if.now_ms    <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        acc_op.mode   = in_if.mode;
        acc_op.key    = in_if.route_key;
        acc_op.metric = in_if.metric;
        acc_op.now    = in_if.now_ms;
        route_exp_q.insert(route_exp_q.size(), table_apply(acc_op));
      end
      if (!in_if.valid || in_if.ready) begin
        if (op_pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt_op = op_pend_q.pop_front();
          in_if.valid     <= 1'b1;
          in_if.mode      <= nxt_op.mode;
          in_if.route_key <= nxt_op.key;
          in_if.metric    <= nxt_op.metric;
          in_if.now_ms    <= nxt_op.now;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      hold_cnt     <= 0;
      hold_done    <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (route_exp_q.size() == 0) begin
          $display("%0t: result with nothing pending: status %0d count %0d",
                   $time, out_if.status, out_if.route_count);
          errors++;
        end else begin
          want = route_exp_q.pop_front();
          if (out_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_if.status);
            errors++;
          end
          if (out_if.aged_count !== want.aged) begin
            $display("%0t: aged_count expected %0d actual %0d",
                     $time, want.aged, out_if.aged_count);
            errors++;
          end
          if (out_if.update_due !== want.upd_due) begin
            $display("%0t: update_due expected %0d actual %0d",
                     $time, want.upd_due, out_if.update_due);
            errors++;
          end
          if (out_if.route_count !== want.count) begin
            $display("%0t: route_count expected %0d actual %0d",
                     $time, want.count, out_if.route_count);
            errors++;
          end
        end
      end
      // long hold-off so the block backs up and stalls its input
      if (hold_arm && !hold_done) begin
        out_if.ready <= 1'b0;
        hold_cnt     <= hold_cnt + 1;
        if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (op_pend_q.size() == 0 && route_exp_q.size() == 0 && !in_if.valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_TIMEOUT;
    cfg_wdata_i     = '0;
    in_if.valid     = 1'b0;
    in_if.mode      = MODE_UPDATE;
    in_if.route_key = '0;
    in_if.metric    = '0;
    in_if.now_ms    = '0;
    out_if.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    hold_arm        = 1'b0;
    errors          = 0;
    idle_cycles     = 0;
    timeout_reg     = TIMEOUT_RST;
    interval_reg    = INTERVAL_RST;
    tbl_count       = 0;
    last_bcast      = '0;
    key_pool[0]     = '0;
    key_pool[1]     = '1;
    for (int i = 2; i < KEY_POOL; i++) key_pool[i] = {16'($urandom), $urandom};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: reset settings, all modes, boundaries of the age and interval tests
    queue_op(MODE_INIT,   '0, '0, 32'd0);
    queue_op(MODE_UPDATE, '0, '0, 32'd100);
    queue_op(MODE_UPDATE, '1, '1, 32'd200);
    queue_op(MODE_UPDATE, '0, 16'h1234, 32'd300);
    queue_op(MODE_REMOVE, 48'h5, '0, 32'd400);
    queue_op(MODE_REMOVE, '1, '0, 32'd500);
    queue_op(MODE_TICK,   '1, '1, 32'd9999);
    queue_op(MODE_TICK,   '0, '0, 32'd10000);
    // fill the table, last insert pushes out the oldest
    for (int k = 1; k <= int'(MAX_ROUTES); k++)
      queue_op(MODE_UPDATE, {16'hA5A5, 32'(k)}, 16'(k), 32'(1000 + 10 * k));
    queue_op(MODE_TICK, '0, '0, 32'd31010);
    queue_op(MODE_TICK, '0, '0, 32'd31020);
    wait_drained();

    gen_now = 32'd40000;
    write_reg(CFG_TIMEOUT, 32'd8000);
    write_reg(CFG_INTERVAL, 32'd3000);
    run_phase(0, 0, 2500, 1'b0);

    write_reg(CFG_TIMEOUT, 32'd1);
    write_reg(CFG_INTERVAL, 32'd1);
    run_phase(87, 0, 3, 1'b0);

    write_reg(CFG_TIMEOUT, 32'hFFFF_FFFF);
    write_reg(CFG_INTERVAL, 32'hFFFF_FFFF);
    run_phase(0, 87, 5000, 1'b0);

    write_reg(CFG_TIMEOUT, 32'($urandom_range(60000, 1000)));
    write_reg(CFG_INTERVAL, 32'($urandom_range(20000, 500)));
    run_phase(16, 16, 4000, 1'b0);

    write_reg(CFG_TIMEOUT, TIMEOUT_RST);
    write_reg(CFG_INTERVAL, INTERVAL_RST);
    run_phase(0, 0, 3000, 1'b1);

    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
